// ===== rtl/felv_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// felv_pkg
// Shared types, constants and fixed-point helpers for the element load
// vector block.
// ----------------------------------------------------------------------------
package felv_pkg;

    // Table sizes and the stored width of a global node number.
    localparam int MAX_NODES        = 16;
    localparam int MAX_QUAD         = 16;
    localparam int NODE_NUMBER_BITS = 24;

    // Index and count widths that follow from the table sizes.
    localparam int NODE_W       = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int QUAD_W       = (MAX_QUAD > 1) ? $clog2(MAX_QUAD) : 1;
    localparam int NODE_CNT_W   = $clog2(MAX_NODES + 1);
    localparam int QUAD_CNT_W   = $clog2(MAX_QUAD + 1);
    localparam int BASIS_DEPTH  = 1 << (NODE_W + QUAD_W);
    localparam int NODE_STORE_W = (NODE_NUMBER_BITS < 24) ? NODE_NUMBER_BITS : 24;

    // Fixed field widths.
    localparam int ROW_W   = 24;
    localparam int VALUE_W = 32;
    localparam int Q18_W   = 18;
    localparam int CFG_W   = 5;

    // Datapath widths: basis*weight product rounded to Q4.16, that times a
    // Q16.16 source, and the sum over all quadrature points.
    localparam int P_W    = 20;
    localparam int PROD_W = 64;
    localparam int ACC_W  = 52 + QUAD_W;
    localparam int RND_W  = 48;

    // Command codes of the input item.
    typedef enum logic [2:0] {
        CMD_LOAD_BASIS  = 3'd0,
        CMD_LOAD_WEIGHT = 3'd1,
        CMD_LOAD_NODE   = 3'd2,
        CMD_LOAD_SOURCE = 3'd3,
        CMD_COMPUTE     = 3'd4
    } t_cmd;

    // Configuration register indexes.
    typedef enum logic {
        CFG_NODES = 1'b0,
        CFG_QUAD  = 1'b1
    } t_cfg_idx;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL_BW,
        ST_ROUND_P,
        ST_MUL_PRE,
        ST_MUL_PIM,
        ST_ACC_IM,
        ST_ROUND_S,
        ST_MUL_SRE,
        ST_MUL_SIM,
        ST_OUT
    } t_state;

    // Operand pair on the shared multiplier.
    typedef enum logic [2:0] {
        MS_BW,
        MS_PRE,
        MS_PIM,
        MS_SRE,
        MS_SIM
    } t_mul_sel;

    // Datapath controls from the sequencer.
    typedef struct packed {
        logic     rd_en;
        logic     det_en;
        t_mul_sel mul_sel;
        logic     prod_en;
        logic     p_en;
        logic     acc_clr;
        logic     acc_re_en;
        logic     acc_im_en;
        logic     s_en;
        logic     c_re_en;
        logic     out_load;
        logic     last;
    } t_ctrl;

    // Saturate a 32-bit value to the Q2.16 range of an 18-bit entry.
    function automatic logic signed [Q18_W-1:0] sat_q18(input logic signed [VALUE_W-1:0] v);
        logic signed [Q18_W-1:0] r;
        if (v > 32'sd131071) begin
            r = 18'sd131071;
        end else if (v < -32'sd131072) begin
            r = -18'sd131072;
        end else begin
            r = v[Q18_W-1:0];
        end
        return r;
    endfunction

    // Saturate to 32-bit signed.
    function automatic logic signed [VALUE_W-1:0] sat_s32(input logic signed [RND_W-1:0] v);
        logic signed [VALUE_W-1:0] r;
        if (v > 48'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -48'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[VALUE_W-1:0];
        end
        return r;
    endfunction

    // Basis times weight, rounded half up from Q4.32 to Q4.16.
    function automatic logic signed [P_W-1:0] round_p(input logic signed [PROD_W-1:0] v);
        logic signed [35:0] t;
        t = v[35:0] + 36'sd32768;
        return t[35:16];
    endfunction

    // Accumulated sum rounded half up to Q.16 and saturated.
    function automatic logic signed [VALUE_W-1:0] round_acc(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] t;
        logic signed [ACC_W-17:0] h;
        t = v + ACC_W'(32768);
        h = t[ACC_W-1:16];
        return sat_s32(RND_W'(h));
    endfunction

    // Scaled product rounded half up to Q16.16 and saturated.
    function automatic logic signed [VALUE_W-1:0] round_prod(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] t;
        t = v + 64'sd32768;
        return sat_s32(t[PROD_W-1:16]);
    endfunction

    // Register value clamped to 1..limit.
    function automatic logic [6:0] clamp_cnt(input logic [CFG_W-1:0] v, input int limit);
        logic [6:0] r;
        if (v == '0) begin
            r = 7'd1;
        end else if (int'(v) > limit) begin
            r = 7'(limit);
        end else begin
            r = 7'(v);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/felv_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// felv_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module felv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                       i_wr_data,
    input  wire logic                                   i_rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/felv_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// felv_ctrl
// Sequencer for the compute transaction: walks local nodes and quadrature
// points, steps the shared multiplier and owns the output valid flag.
// ----------------------------------------------------------------------------
module felv_ctrl
    import felv_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic [2:0]        i_command,
    input  wire logic              i_out_stall,
    input  wire logic [CFG_W-1:0]  i_nodes_cfg,
    input  wire logic [CFG_W-1:0]  i_quad_cfg,
    output logic                   o_in_stall,
    output logic                   o_out_valid,
    output logic [NODE_W-1:0]      o_node,
    output logic [QUAD_W-1:0]      o_quad,
    output t_ctrl                  o_ctrl
);

    t_state              r_state, n_state;
    logic [NODE_W-1:0]   r_node, n_node;
    logic [QUAD_W-1:0]   r_quad, n_quad;
    logic                r_out_valid, n_out_valid;

    logic [NODE_CNT_W-1:0] nn;
    logic [QUAD_CNT_W-1:0] nq;
    logic                  last_q;
    logic                  last_n;
    logic                  out_free;
    logic                  start;

    // Effective counts and loop ends.
    always_comb begin
        logic [6:0] nn_full;
        logic [6:0] nq_full;
        nn_full  = clamp_cnt(i_nodes_cfg, MAX_NODES);
        nq_full  = clamp_cnt(i_quad_cfg, MAX_QUAD);
        nn       = nn_full[NODE_CNT_W-1:0];
        nq       = nq_full[QUAD_CNT_W-1:0];
        last_q   = (QUAD_CNT_W'(r_quad) + QUAD_CNT_W'(1)) == nq;
        last_n   = (NODE_CNT_W'(r_node) + NODE_CNT_W'(1)) == nn;
        out_free = !r_out_valid || !i_out_stall;
        start    = (r_state == ST_IDLE) && i_in_valid && (i_command == CMD_COMPUTE);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:    if (start) n_state = ST_READ;
            ST_READ:    n_state = ST_MUL_BW;
            ST_MUL_BW:  n_state = ST_ROUND_P;
            ST_ROUND_P: n_state = ST_MUL_PRE;
            ST_MUL_PRE: n_state = ST_MUL_PIM;
            ST_MUL_PIM: n_state = ST_ACC_IM;
            ST_ACC_IM:  n_state = last_q ? ST_ROUND_S : ST_READ;
            ST_ROUND_S: n_state = ST_MUL_SRE;
            ST_MUL_SRE: n_state = ST_MUL_SIM;
            ST_MUL_SIM: n_state = ST_OUT;
            ST_OUT: begin
                if (out_free) begin
                    n_state = last_n ? ST_IDLE : ST_READ;
                end
            end
            default:    n_state = ST_IDLE;
        endcase
    end

    // Datapath controls.
    always_comb begin
        o_ctrl          = '0;
        o_ctrl.mul_sel  = MS_BW;
        o_ctrl.last     = last_n;
        unique case (r_state)
            ST_IDLE: begin
                o_ctrl.acc_clr = 1'b1;
                o_ctrl.det_en  = start;
            end
            ST_READ:    o_ctrl.rd_en = 1'b1;
            ST_MUL_BW: begin
                o_ctrl.mul_sel = MS_BW;
                o_ctrl.prod_en = 1'b1;
            end
            ST_ROUND_P: o_ctrl.p_en = 1'b1;
            ST_MUL_PRE: begin
                o_ctrl.mul_sel = MS_PRE;
                o_ctrl.prod_en = 1'b1;
            end
            ST_MUL_PIM: begin
                o_ctrl.mul_sel   = MS_PIM;
                o_ctrl.prod_en   = 1'b1;
                o_ctrl.acc_re_en = 1'b1;
            end
            ST_ACC_IM:  o_ctrl.acc_im_en = 1'b1;
            ST_ROUND_S: o_ctrl.s_en = 1'b1;
            ST_MUL_SRE: begin
                o_ctrl.mul_sel = MS_SRE;
                o_ctrl.prod_en = 1'b1;
            end
            ST_MUL_SIM: begin
                o_ctrl.mul_sel = MS_SIM;
                o_ctrl.prod_en = 1'b1;
                o_ctrl.c_re_en = 1'b1;
            end
            ST_OUT: begin
                o_ctrl.acc_clr  = 1'b1;
                o_ctrl.out_load = out_free;
            end
            default: begin
                o_ctrl.acc_clr = 1'b1;
            end
        endcase
    end

    // Loop counters and the output valid flag.
    always_comb begin
        n_node      = r_node;
        n_quad      = r_quad;
        n_out_valid = (r_out_valid && i_out_stall) || o_ctrl.out_load;
        if (r_state == ST_IDLE) begin
            n_node = '0;
            n_quad = '0;
        end else if (r_state == ST_ACC_IM) begin
            n_quad = last_q ? '0 : r_quad + QUAD_W'(1);
        end else if (o_ctrl.out_load && !last_n) begin
            n_node = r_node + NODE_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_node      <= '0;
            r_quad      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_node      <= n_node;
            r_quad      <= n_quad;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_node      = r_node;
    assign o_quad      = r_quad;

endmodule
`default_nettype wire

// ===== rtl/felv_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// felv_dp
// Datapath around one shared 32x32 signed multiplier: product rounding,
// complex accumulation, determinant scaling and the result register.
// ----------------------------------------------------------------------------
module felv_dp
    import felv_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire t_ctrl                      i_ctrl,
    input  wire logic signed [VALUE_W-1:0]  i_det,
    input  wire logic signed [Q18_W-1:0]    i_basis,
    input  wire logic signed [Q18_W-1:0]    i_weight,
    input  wire logic signed [VALUE_W-1:0]  i_src_re,
    input  wire logic signed [VALUE_W-1:0]  i_src_im,
    input  wire logic [NODE_STORE_W-1:0]    i_node_number,
    output logic [ROW_W-1:0]                o_row_number,
    output logic signed [VALUE_W-1:0]       o_coef_re,
    output logic signed [VALUE_W-1:0]       o_coef_im,
    output logic                            o_last
);

    logic signed [VALUE_W-1:0] r_det;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [P_W-1:0]     r_p;
    logic signed [ACC_W-1:0]   r_acc_re;
    logic signed [ACC_W-1:0]   r_acc_im;
    logic signed [VALUE_W-1:0] r_s_re;
    logic signed [VALUE_W-1:0] r_s_im;
    logic signed [VALUE_W-1:0] r_c_re;

    logic signed [VALUE_W-1:0] mul_a;
    logic signed [VALUE_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  mul_y;

    // Operand selection for the shared multiplier.
    always_comb begin
        case (i_ctrl.mul_sel)
            MS_BW: begin
                mul_a = VALUE_W'(i_basis);
                mul_b = VALUE_W'(i_weight);
            end
            MS_PRE: begin
                mul_a = VALUE_W'(r_p);
                mul_b = i_src_re;
            end
            MS_PIM: begin
                mul_a = VALUE_W'(r_p);
                mul_b = i_src_im;
            end
            MS_SRE: begin
                mul_a = r_s_re;
                mul_b = r_det;
            end
            MS_SIM: begin
                mul_a = r_s_im;
                mul_b = r_det;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_y = mul_a * mul_b;
    end

    // Multiplier output, rounded product and determinant.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.det_en) begin
            r_det <= i_det;
        end
        if (i_ctrl.prod_en) begin
            r_prod <= mul_y;
        end
        if (i_ctrl.p_en) begin
            r_p <= round_p(r_prod);
        end
    end

    // Complex accumulation over the quadrature points of one node.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.acc_clr) begin
            r_acc_re <= '0;
            r_acc_im <= '0;
        end else begin
            if (i_ctrl.acc_re_en) begin
                r_acc_re <= r_acc_re + r_prod[ACC_W-1:0];
            end
            if (i_ctrl.acc_im_en) begin
                r_acc_im <= r_acc_im + r_prod[ACC_W-1:0];
            end
        end
    end

    // Rounded sums and the scaled real part.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.s_en) begin
            r_s_re <= round_acc(r_acc_re);
            r_s_im <= round_acc(r_acc_im);
        end
        if (i_ctrl.c_re_en) begin
            r_c_re <= round_prod(r_prod);
        end
    end

    // Result register; the multiplier still holds the scaled imaginary part.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.out_load) begin
            o_row_number <= ROW_W'(i_node_number);
            o_coef_re    <= r_c_re;
            o_coef_im    <= round_prod(r_prod);
            o_last       <= i_ctrl.last;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/fem_element_load_vector.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fem_element_load_vector
// Finite-element load vector assembly for one element at a time.
// ----------------------------------------------------------------------------
// Input transactions (i_in_valid / o_in_stall) either load one table entry
// (basis, weight, node number, complex source) or start a compute. A compute
// produces one output transaction per local node in use, carrying the global
// node number, the complex coefficient and a last flag on the final node.
// For each local node, a compute steps every quadrature point through a table
// read, the basis*weight product, its rounding and the real and imaginary
// source products that are summed, then rounds the sums, scales both by the
// determinant and loads the output register; the single shared multiplier
// and the registered table reads set this order. o_in_stall stays high for
// the whole compute. Each result sits in an output register; if the receiver
// holds i_out_stall the sequencer waits in its output step until the register
// frees up, and nothing is lost or repeated.
// The configuration port (i_cfg_valid / o_cfg_ready) is always ready and must
// only be written while the block is idle. Reset sets both counts to 3 and
// leaves the tables unwritten; there is no clearing pass.
// ----------------------------------------------------------------------------
module fem_element_load_vector
    import felv_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // Input channel
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire logic [2:0]                 i_command,
    input  wire logic [3:0]                 i_node_slot,
    input  wire logic [3:0]                 i_quad_slot,
    input  wire logic [23:0]                i_node_number,
    input  wire logic signed [VALUE_W-1:0]  i_value_re,
    input  wire logic signed [VALUE_W-1:0]  i_value_im,
    // Output channel
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output logic [ROW_W-1:0]                o_row_number,
    output logic signed [VALUE_W-1:0]       o_coef_re,
    output logic signed [VALUE_W-1:0]       o_coef_im,
    output logic                            o_last,
    // Configuration port
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic                       i_cfg_index,
    input  wire logic [CFG_W-1:0]           i_cfg_data
);

    logic [CFG_W-1:0] r_nodes_cfg;
    logic [CFG_W-1:0] r_quad_cfg;

    t_ctrl              ctrl;
    logic [NODE_W-1:0]  seq_node;
    logic [QUAD_W-1:0]  seq_quad;

    logic               in_acc;
    logic               node_ok;
    logic               quad_ok;
    logic               wr_basis;
    logic               wr_weight;
    logic               wr_node;
    logic               wr_source;
    logic [NODE_W-1:0]  wr_node_idx;
    logic [QUAD_W-1:0]  wr_quad_idx;

    logic [Q18_W-1:0]          basis_rd;
    logic [Q18_W-1:0]          weight_rd;
    logic [2*VALUE_W-1:0]      source_rd;
    logic [NODE_STORE_W-1:0]   node_rd;

    // Configuration registers.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nodes_cfg <= CFG_W'(3);
            r_quad_cfg  <= CFG_W'(3);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_NODES: r_nodes_cfg <= i_cfg_data;
                CFG_QUAD:  r_quad_cfg  <= i_cfg_data;
                default:   r_nodes_cfg <= r_nodes_cfg;
            endcase
        end
    end

    // Load decode; slots beyond the tables are dropped.
    always_comb begin
        in_acc      = i_in_valid && !o_in_stall;
        node_ok     = int'(i_node_slot) < MAX_NODES;
        quad_ok     = int'(i_quad_slot) < MAX_QUAD;
        wr_node_idx = NODE_W'(i_node_slot);
        wr_quad_idx = QUAD_W'(i_quad_slot);
        wr_basis    = in_acc && (i_command == CMD_LOAD_BASIS) && node_ok && quad_ok;
        wr_weight   = in_acc && (i_command == CMD_LOAD_WEIGHT) && quad_ok;
        wr_node     = in_acc && (i_command == CMD_LOAD_NODE) && node_ok;
        wr_source   = in_acc && (i_command == CMD_LOAD_SOURCE) && quad_ok;
    end

    // Element tables.
    felv_ram #(.WIDTH(Q18_W), .DEPTH(BASIS_DEPTH)) u_basis_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_basis),
        .i_wr_addr ({wr_node_idx, wr_quad_idx}),
        .i_wr_data (sat_q18(i_value_re)),
        .i_rd_en   (ctrl.rd_en),
        .i_rd_addr ({seq_node, seq_quad}),
        .o_rd_data (basis_rd)
    );

    felv_ram #(.WIDTH(Q18_W), .DEPTH(MAX_QUAD)) u_weight_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_weight),
        .i_wr_addr (wr_quad_idx),
        .i_wr_data (sat_q18(i_value_re)),
        .i_rd_en   (ctrl.rd_en),
        .i_rd_addr (seq_quad),
        .o_rd_data (weight_rd)
    );

    felv_ram #(.WIDTH(2 * VALUE_W), .DEPTH(MAX_QUAD)) u_source_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_source),
        .i_wr_addr (wr_quad_idx),
        .i_wr_data ({i_value_im, i_value_re}),
        .i_rd_en   (ctrl.rd_en),
        .i_rd_addr (seq_quad),
        .o_rd_data (source_rd)
    );

    felv_ram #(.WIDTH(NODE_STORE_W), .DEPTH(MAX_NODES)) u_node_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_node),
        .i_wr_addr (wr_node_idx),
        .i_wr_data (NODE_STORE_W'(i_node_number)),
        .i_rd_en   (ctrl.rd_en),
        .i_rd_addr (seq_node),
        .o_rd_data (node_rd)
    );

    // Sequencer.
    felv_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_command   (i_command),
        .i_out_stall (i_out_stall),
        .i_nodes_cfg (r_nodes_cfg),
        .i_quad_cfg  (r_quad_cfg),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_node      (seq_node),
        .o_quad      (seq_quad),
        .o_ctrl      (ctrl)
    );

    // Arithmetic and result register.
    felv_dp u_dp (
        .i_clk         (i_clk),
        .i_ctrl        (ctrl),
        .i_det         (i_value_re),
        .i_basis       (basis_rd),
        .i_weight      (weight_rd),
        .i_src_re      (source_rd[VALUE_W-1:0]),
        .i_src_im      (source_rd[2*VALUE_W-1:VALUE_W]),
        .i_node_number (node_rd),
        .o_row_number  (o_row_number),
        .o_coef_re     (o_coef_re),
        .o_coef_im     (o_coef_im),
        .o_last        (o_last)
    );

endmodule
`default_nettype wire
